// File: hw/rtl/dpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpm_pkg
// Types and constants shared by the duotone pixel map pipeline.
// ----------------------------------------------------------------------------
package dpm_pkg;

	localparam int unsigned PIX_W  = 24;
	localparam int unsigned CH_W   = 8;
	localparam int unsigned N_CH   = 3;
	localparam int unsigned LUMA_W = 24;
	localparam int unsigned FRAC_W = 17;
	localparam int unsigned BOOST_W = 19;

	typedef logic [PIX_W-1:0]  rgb_t;
	typedef logic [CH_W-1:0]   chan_t;
	typedef logic [LUMA_W-1:0] luma_t;
	typedef logic [FRAC_W-1:0] frac_t;

	// register map of the configuration port
	typedef enum logic [0:0] {
		CFG_SHADOW    = 1'b0,
		CFG_HIGHLIGHT = 1'b1
	} cfg_idx_t;

	localparam rgb_t SHADOW_RST    = 24'h000000;
	localparam rgb_t HIGHLIGHT_RST = 24'hFFFFFF;

	// Rec.709 weights in Q0.16, summing to one
	localparam logic [15:0] W_RED   = 16'd13933;
	localparam logic [15:0] W_GREEN = 16'd46871;
	localparam logic [15:0] W_BLUE  = 16'd4732;

	// 2^24 / 255 rounded, and the rounding term for the >> 24
	localparam logic [16:0] RECIP_255 = 17'd65793;
	localparam logic [40:0] NORM_RND  = 41'h0_0080_0000;

	// contrast boost in quarter units: 5t - 1/2, clamped to 0..4
	localparam logic [BOOST_W-1:0] BOOST_LO  = 19'd32768;
	localparam logic [BOOST_W-1:0] BOOST_HI  = 19'd294912;
	localparam logic [BOOST_W-1:0] BOOST_RND = 19'd32766;
	localparam frac_t              FRAC_ONE  = 17'd65536;

endpackage

// File: hw/rtl/dpm_pix_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpm_pix_in_if
// Source pixel stream: valid/ready handshake with one packed RGB pixel.
// ----------------------------------------------------------------------------
interface dpm_pix_in_if;
	logic          valid;
	logic          ready;
	dpm_pkg::rgb_t pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink   (input valid, input pixel_in, output ready);
endinterface

// File: hw/rtl/dpm_pix_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpm_pix_out_if
// Duotone pixel stream: valid/ready handshake with one packed RGB pixel.
// ----------------------------------------------------------------------------
interface dpm_pix_out_if;
	logic          valid;
	logic          ready;
	dpm_pkg::rgb_t pixel_out;

	modport source (output valid, output pixel_out, input ready);
	modport sink   (input valid, input pixel_out, output ready);
endinterface

// File: hw/rtl/dpm_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpm_cfg_if
// Register write channel: valid/ready handshake with index and write data.
// ----------------------------------------------------------------------------
interface dpm_cfg_if;
	logic              valid;
	logic              ready;
	dpm_pkg::cfg_idx_t index;
	dpm_pkg::rgb_t     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/dpm_luma.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpm_luma
// Stages 1 and 2: Rec.709 luminance, then normalisation to a Q1.16 fraction.
// ----------------------------------------------------------------------------
module dpm_luma (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  dpm_pkg::rgb_t  in_pixel,
	output logic           out_valid,
	input  logic           out_ready,
	output dpm_pkg::frac_t out_frac
);

	logic           valid_s1;
	logic           valid_s2;
	dpm_pkg::luma_t luma_s1;
	dpm_pkg::frac_t frac_s2;
	logic           adv_s1;
	logic           adv_s2;
	dpm_pkg::luma_t luma_next;
	logic [40:0]    norm_prod;

	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_comb begin
		luma_next = 24'(dpm_pkg::W_RED)   * 24'(in_pixel[23:16])
		          + 24'(dpm_pkg::W_GREEN) * 24'(in_pixel[15:8])
		          + 24'(dpm_pkg::W_BLUE)  * 24'(in_pixel[7:0]);
		// multiply by the reciprocal of 255, round, keep Q1.16
		norm_prod = 41'(luma_s1) * 41'(dpm_pkg::RECIP_255) + dpm_pkg::NORM_RND;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && adv_s1) luma_s1 <= luma_next;
		if (valid_s1 && adv_s2) frac_s2 <= norm_prod[40:24];
	end

	assign out_valid = valid_s2;
	assign out_frac  = frac_s2;

endmodule

// File: hw/rtl/dpm_contrast.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpm_contrast
// Stage 3: contrast boost 1.25*t - 0.125, clamped to [0,1], rounded half up.
// ----------------------------------------------------------------------------
module dpm_contrast (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  dpm_pkg::frac_t in_frac,
	output logic           out_valid,
	input  logic           out_ready,
	output dpm_pkg::frac_t out_frac
);

	logic                          valid_s3;
	dpm_pkg::frac_t                frac_s3;
	logic                          adv_s3;
	logic [dpm_pkg::BOOST_W-1:0]   t5;
	logic [dpm_pkg::BOOST_W-1:0]   t5_off;
	dpm_pkg::frac_t                boost;

	assign adv_s3   = !valid_s3 || out_ready;
	assign in_ready = adv_s3;

	always_comb begin
		t5     = {in_frac, 2'b00} + dpm_pkg::BOOST_W'(in_frac);
		t5_off = t5 - dpm_pkg::BOOST_RND;
		priority if (t5 <= dpm_pkg::BOOST_LO) begin
			boost = '0;
		end else if (t5 >= dpm_pkg::BOOST_HI) begin
			boost = dpm_pkg::FRAC_ONE;
		end else begin
			// quarter units back to Q1.16 with the half-up term folded in
			boost = t5_off[dpm_pkg::BOOST_W-1:2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv_s3) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && adv_s3) frac_s3 <= boost;
	end

	assign out_valid = valid_s3;
	assign out_frac  = frac_s3;

endmodule

// File: hw/rtl/dpm_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpm_blend
// Stage 4: per-channel blend from shadow to highlight colour, output register.
// ----------------------------------------------------------------------------
module dpm_blend (
	input  logic           clk,
	input  logic           arst_n,
	input  dpm_pkg::rgb_t  shadow,
	input  dpm_pkg::rgb_t  highlight,
	input  logic           in_valid,
	output logic           in_ready,
	input  dpm_pkg::frac_t in_frac,
	output logic           out_valid,
	input  logic           out_ready,
	output dpm_pkg::rgb_t  out_pixel
);

	logic                 valid_s4;
	dpm_pkg::rgb_t        pixel_s4;
	logic                 adv_s4;
	dpm_pkg::rgb_t        blended;
	logic signed [17:0]   frac_sg;
	logic signed [8:0]    diff  [dpm_pkg::N_CH];
	logic signed [26:0]   prod  [dpm_pkg::N_CH];
	logic signed [26:0]   acc   [dpm_pkg::N_CH];
	dpm_pkg::chan_t       s_ch  [dpm_pkg::N_CH];
	dpm_pkg::chan_t       h_ch  [dpm_pkg::N_CH];

	assign adv_s4   = !valid_s4 || out_ready;
	assign in_ready = adv_s4;

	always_comb begin
		frac_sg = $signed({1'b0, in_frac});
		blended = '0;
		for (int i = 0; i < dpm_pkg::N_CH; i++) begin
			s_ch[i] = shadow[i*dpm_pkg::CH_W +: dpm_pkg::CH_W];
			h_ch[i] = highlight[i*dpm_pkg::CH_W +: dpm_pkg::CH_W];
			diff[i] = $signed({1'b0, h_ch[i]}) - $signed({1'b0, s_ch[i]});
			prod[i] = diff[i] * frac_sg;
			// s*65536 plus half an lsb; the sum stays between s and h
			acc[i]  = $signed({3'b000, s_ch[i], 16'h8000}) + prod[i];
			blended[i*dpm_pkg::CH_W +: dpm_pkg::CH_W] = acc[i][23:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv_s4) begin
			valid_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && adv_s4) pixel_s4 <= blended;
	end

	assign out_valid = valid_s4;
	assign out_pixel = pixel_s4;

endmodule

// File: hw/rtl/duotone_pixel_map_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// duotone_pixel_map_core
// Maps each RGB pixel to a duotone pixel through Rec.709 luma and a
// contrast-boosted blend between programmable shadow and highlight colours.
//
//   channel  | dir | payload               | handshake
//   ---------+-----+-----------------------+-------------------
//   pix_in   | in  | pixel_in[23:0]        | valid / ready
//   pix_out  | out | pixel_out[23:0]       | valid / ready
//   cfg      | in  | index, data[23:0]     | valid / ready (always ready)
//
// four register stages: luma, normalise, contrast boost, blend
// one pixel per clock sustained while pix_out.ready stays high
// each stage holds when the one after it is full and stalled; bubbles close up
// reset clears all stage valid bits and loads the default colours
// ----------------------------------------------------------------------------
module duotone_pixel_map_core (
	input  logic          clk,
	input  logic          arst_n,
	dpm_pix_in_if.sink    pix_in,
	dpm_pix_out_if.source pix_out,
	dpm_cfg_if.sink       cfg
);

	dpm_pkg::rgb_t  shadow_q;
	dpm_pkg::rgb_t  highlight_q;
	logic           luma_valid;
	logic           luma_ready;
	dpm_pkg::frac_t luma_frac;
	logic           boost_valid;
	logic           boost_ready;
	dpm_pkg::frac_t boost_frac;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_q    <= dpm_pkg::SHADOW_RST;
			highlight_q <= dpm_pkg::HIGHLIGHT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				dpm_pkg::CFG_SHADOW:    shadow_q    <= cfg.data;
				dpm_pkg::CFG_HIGHLIGHT: highlight_q <= cfg.data;
				default: ;
			endcase
		end
	end

	dpm_luma u_luma (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix_in.valid),
		.in_ready  (pix_in.ready),
		.in_pixel  (pix_in.pixel_in),
		.out_valid (luma_valid),
		.out_ready (luma_ready),
		.out_frac  (luma_frac)
	);

	dpm_contrast u_contrast (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (luma_valid),
		.in_ready  (luma_ready),
		.in_frac   (luma_frac),
		.out_valid (boost_valid),
		.out_ready (boost_ready),
		.out_frac  (boost_frac)
	);

	dpm_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.shadow    (shadow_q),
		.highlight (highlight_q),
		.in_valid  (boost_valid),
		.in_ready  (boost_ready),
		.in_frac   (boost_frac),
		.out_valid (pix_out.valid),
		.out_ready (pix_out.ready),
		.out_pixel (pix_out.pixel_out)
	);

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the duotone pixel map core. Pixels go in through a
// queue-fed driver with random gaps, results are checked by a monitor against
// a fixed-point luma, contrast and blend calculation, over several colour pairs.
// ----------------------------------------------------------------------------
module tb;

	localparam longint LUMA_R      = 13933;
	localparam longint LUMA_G      = 46871;
	localparam longint LUMA_B      = 4732;
	localparam longint INV_255     = 65793;
	localparam longint UNITY       = 65536;
	localparam int     CYCLE_LIMIT = 200000;
	localparam int     RAND_ITEMS  = 138;

	logic clk;
	logic arst_n;

	dpm_pix_in_if  pix_in ();
	dpm_pix_out_if pix_out ();
	dpm_cfg_if     cfg ();

	duotone_pixel_map_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_in),
		.pix_out (pix_out),
		.cfg     (cfg)
	);

	dpm_pkg::rgb_t source_pixels [$];
	dpm_pkg::rgb_t duotone_expected [$];
	dpm_pkg::rgb_t shadow_model;
	dpm_pkg::rgb_t highlight_model;
	dpm_pkg::rgb_t want_pixel;
	logic          pix_taken;
	int            gap_pct;
	int            mismatch_count;
	int            cycle_count;

	// luma, normalise to a q1.16 fraction, boost contrast, then blend per channel
	function automatic dpm_pkg::rgb_t duotone_of(dpm_pkg::rgb_t px, dpm_pkg::rgb_t dark,
			dpm_pkg::rgb_t bright);
		longint        luma;
		longint        frac;
		longint        boost;
		longint        mix;
		longint        lvl;
		dpm_pkg::rgb_t res;
		luma = LUMA_R * longint'(px[23:16]) + LUMA_G * longint'(px[15:8])
			+ LUMA_B * longint'(px[7:0]);
		frac = (luma * INV_255 + 64'sd8388608) >>> 24;
		boost = 5 * frac - 32768;
		if (boost <= 0) begin
			mix = 0;
		end else if (boost >= 4 * UNITY) begin
			mix = UNITY;
		end else begin
			mix = (boost + 2) >>> 2;
		end
		for (int ch = 0; ch < 3; ch++) begin
			lvl = (longint'(dark[ch*8 +: 8]) * UNITY
				+ (longint'(bright[ch*8 +: 8]) - longint'(dark[ch*8 +: 8])) * mix
				+ 32768) >>> 16;
			res[ch*8 +: 8] = lvl[7:0];
		end
		return res;
	endfunction

	task automatic flag_mismatch(string what);
		$display("MISMATCH at cycle %0d: %s", cycle_count, what);
		mismatch_count++;
	endtask

	task automatic write_register(dpm_pkg::cfg_idx_t idx, dpm_pkg::rgb_t val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		do @(posedge clk); while (!cfg.ready);
		if (idx == dpm_pkg::CFG_SHADOW) begin
			shadow_model = val;
		end else begin
			highlight_model = val;
		end
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (source_pixels.size() != 0 || pix_in.valid || duotone_expected.size() != 0);
	endtask

	// extremes, primaries, and greys either side of both clamp points
	task automatic queue_corner_pixels();
		source_pixels.push_back(24'h000000);
		source_pixels.push_back(24'hFFFFFF);
		source_pixels.push_back(24'hFF0000);
		source_pixels.push_back(24'h00FF00);
		source_pixels.push_back(24'h0000FF);
		source_pixels.push_back(24'h00FFFF);
		source_pixels.push_back(24'hFFFF00);
		source_pixels.push_back(24'h191919);
		source_pixels.push_back(24'h1A1A1A);
		source_pixels.push_back(24'hE5E5E5);
		source_pixels.push_back(24'hE6E6E6);
		source_pixels.push_back(24'h7F7F7F);
		source_pixels.push_back(24'h808080);
		source_pixels.push_back(24'h123456);
		source_pixels.push_back(24'hA5A5A5);
		source_pixels.push_back(24'h5A5A5A);
		source_pixels.push_back(24'h010101);
		source_pixels.push_back(24'hFEFEFE);
		source_pixels.push_back(24'hAA55AA);
		source_pixels.push_back(24'h55AA55);
	endtask

	task automatic queue_random_pixels(int count);
		dpm_pkg::rgb_t px;
		logic [7:0]    grey;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(3) == 0) begin
				// near-grey pixels sweep the luma range evenly
				grey = 8'($urandom_range(255));
				px = {grey, grey, grey} ^ dpm_pkg::rgb_t'($urandom() & 32'h0003_0303);
			end else begin
				px = dpm_pkg::rgb_t'($urandom());
			end
			source_pixels.push_back(px);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// driver: hold the pixel until its transfer, then load the next or go idle
	always @(negedge clk) begin
		if (arst_n) begin
			if (!pix_in.valid || pix_taken) begin
				if (source_pixels.size() != 0 && $urandom_range(99) >= gap_pct) begin
					pix_in.valid    <= 1'b1;
					pix_in.pixel_in <= source_pixels.pop_front();
				end else begin
					pix_in.valid <= 1'b0;
				end
			end
			pix_out.ready <= ($urandom_range(99) >= gap_pct);
		end
	end

	// monitor: predict on input transfer, check on output transfer
	always @(posedge clk) begin
		if (arst_n) begin
			pix_taken <= pix_in.valid && pix_in.ready;
			if (pix_in.valid && pix_in.ready) begin
				duotone_expected.push_back(
					duotone_of(pix_in.pixel_in, shadow_model, highlight_model));
			end
			if (pix_out.valid && pix_out.ready) begin
				if (duotone_expected.size() == 0) begin
					flag_mismatch($sformatf("pixel %06h with none pending",
						pix_out.pixel_out));
				end else begin
					want_pixel = duotone_expected.pop_front();
					if (pix_out.pixel_out !== want_pixel) begin
						flag_mismatch($sformatf("pixel_out %06h, want %06h",
							pix_out.pixel_out, want_pixel));
					end
				end
			end
		end
	end

	initial begin
		dpm_pkg::rgb_t dark;
		dpm_pkg::rgb_t bright;
		arst_n          = 1'b0;
		pix_in.valid    = 1'b0;
		pix_in.pixel_in = '0;
		pix_out.ready   = 1'b0;
		cfg.valid       = 1'b0;
		cfg.index       = dpm_pkg::CFG_SHADOW;
		cfg.data        = '0;
		pix_taken       = 1'b0;
		gap_pct         = 33;
		mismatch_count  = 0;
		cycle_count     = 0;
		shadow_model    = dpm_pkg::SHADOW_RST;
		highlight_model = dpm_pkg::HIGHLIGHT_RST;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset colours first
		queue_corner_pixels();
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					// shadow brighter than highlight: mapping runs backwards
					dark   = 24'hFFFFFF;
					bright = 24'h000000;
				end
				1: begin
					dark   = 24'h000000;
					bright = 24'hFFFFFF;
				end
				4: begin
					dark   = dpm_pkg::rgb_t'($urandom());
					bright = dark;
				end
				default: begin
					dark   = dpm_pkg::rgb_t'($urandom());
					bright = dpm_pkg::rgb_t'($urandom());
				end
			endcase
			gap_pct = (ph == 2) ? 0 : 33;
			write_register(dpm_pkg::CFG_SHADOW, dark);
			write_register(dpm_pkg::CFG_HIGHLIGHT, bright);
			if (ph == 0) begin
				queue_corner_pixels();
			end
			queue_random_pixels(RAND_ITEMS);
			wait_drained();
		end

		repeat (12) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/dpm_pkg.sv
hw/rtl/dpm_pix_in_if.sv
hw/rtl/dpm_pix_out_if.sv
hw/rtl/dpm_cfg_if.sv
hw/rtl/dpm_luma.sv
hw/rtl/dpm_contrast.sv
hw/rtl/dpm_blend.sv
hw/rtl/duotone_pixel_map_core.sv
test/tb.sv
